// File: src/wtse_pkg.sv
// Shared types, constants and table builders for the wind spectrum evaluator.
package wtse_pkg;

    localparam int FREQ_W   = 24;
    localparam int HEIGHT_W = 18;
    localparam int SPEED_W  = 16;
    localparam int SHEAR_W  = 16;
    localparam int CFG_W    = 16;
    localparam int DENS_W   = 40;
    localparam int STATUS_W = 2;

    localparam int H7_W   = 21;
    localparam int DVS_W  = 22;
    localparam int FH_W   = 45;
    localparam int N1_W   = 69;
    localparam int NUMA_W = 53;
    localparam int QA_W   = 48;
    localparam int V_W    = 49;
    localparam int Q1_W   = 64;
    localparam int NUM3_W = 56;
    localparam int B_W    = 63;
    localparam int Q3_W   = 40;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_SHAPE = 2'd1;
    localparam logic [1:0] REG_FORM  = 2'd2;

    localparam logic [CFG_W-1:0] GAIN_RESET  = 16'd26880;
    localparam logic [CFG_W-1:0] SHAPE_RESET = 16'd8448;

    localparam logic [B_W-1:0] POW_MAX = 63'h4000_0000_0000_0000;
    localparam logic [B_W-1:0] ONE_Q16 = 63'd65536;

    // floor(x/3) = (x * RECIP3) >> 30 for x below 2^28
    localparam logic [30:0] RECIP3 = 31'h1555_5556;
    // 3*2^26 - 5*2^20: keeps 5*lg positive, removes the Q16 exponent bias of 16
    localparam logic [27:0] U_BIAS = 28'd196083712;
    // 1024 from the bias above plus 14 for the Q30 to Q16 move
    localparam logic [10:0] IP_BIAS = 11'd1038;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [N1_W-1:0]  n1;
        logic [DVS_W-1:0] dvs;
        logic             zero;
    } wtse_carry_t;

    typedef struct packed {
        logic [B_W-1:0] bq;
        logic           zero;
    } wtse_tail_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bv;
        n   = n_in;
        res = '0;
        bv  = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++)
        begin
            if (bv > n)
            begin
                bv = bv >> 2;
            end
        end
        for (int k = 0; k < 32; k++)
        begin
            if (bv != 64'd0)
            begin
                if (n >= res + bv)
                begin
                    n   = n - (res + bv);
                    res = (res >> 1) + bv;
                end
                else
                begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

    // log2(1 + i/2^tb) in Q16 by repeated squaring
    function automatic logic [16:0] log_entry(input int tb, input int i);
        logic [63:0] mn;
        logic [16:0] lf;
        mn = '0;
        lf = '0;
        if (i == (1 << tb))
        begin
            lf = 17'd65536;
        end
        else
        begin
            mn = 64'((1 << tb) + i) << (30 - tb);
            for (int j = 0; j < 16; j++)
            begin
                mn = (mn * mn) >> 30;
                lf = lf << 1;
                if (mn >= 64'h8000_0000)
                begin
                    mn    = mn >> 1;
                    lf[0] = 1'b1;
                end
            end
        end
        return lf;
    endfunction

    // 2^(i/2^tb) in Q30 from products of repeated square roots of 2
    function automatic logic [31:0] exp_entry(input int tb, input int i);
        logic [63:0] roots [13];
        logic [63:0] acc;
        for (int j = 0; j < 13; j++)
        begin
            roots[j] = '0;
        end
        roots[0] = 64'h8000_0000;
        for (int j = 1; j <= tb; j++)
        begin
            roots[j] = isqrt64(roots[j-1] << 30);
        end
        acc = 64'h4000_0000;
        if (i == (1 << tb))
        begin
            acc = 64'h8000_0000;
        end
        else
        begin
            for (int j = 0; j < tb; j++)
            begin
                if (((i >> j) & 1) != 0)
                begin
                    acc = (acc * roots[tb-j]) >> 30;
                end
            end
        end
        return acc[31:0];
    endfunction

endpackage

// File: src/wtse_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module wtse_div #(
    parameter int NW = 53,
    parameter int DW = 22,
    parameter int QW = 48,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    // upper numerator bits must already be below the divisor
    localparam int HW = NW - QW;

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] sq_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] sq_next  [QW];

    generate
        for (genvar k = 0; k < QW; k++)
        begin : g_stage
            logic [DW-1:0] rem_prev;
            logic [QW-1:0] sq_prev;
            logic [DW-1:0] den_prev;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign rem_prev = {{(DW-HW){1'b0}}, num[NW-1:QW]};
                assign sq_prev  = num[QW-1:0];
                assign den_prev = den;
            end
            else
            begin : g_next
                assign rem_prev = rem_reg[k-1];
                assign sq_prev  = sq_reg[k-1];
                assign den_prev = den_reg[k-1];
            end

            assign trial       = {rem_prev, sq_prev[QW-1]};
            assign diff        = trial - {1'b0, den_prev};
            assign ge          = trial >= {1'b0, den_prev};
            assign rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            assign sq_next[k]  = {sq_prev[QW-2:0], ge};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QW-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0]  <= den;
        side_reg[0] <= side_in;
        for (int k = 0; k < QW; k++)
        begin
            rem_reg[k] <= rem_next[k];
            sq_reg[k]  <= sq_next[k];
        end
        for (int k = 1; k < QW; k++)
        begin
            den_reg[k]  <= den_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign quot     = sq_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

// File: src/wind_turbulence_spectrum_eval.sv
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Depth is set by three bit-serial divider pipelines (48, 64 and 40 stages) plus
// 16 stages of multiply, log2/exp2 table and shift logic.
// Reset clears all stage valid bits and loads the register defaults; tables are constant.
module wind_turbulence_spectrum_eval
    import wtse_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FREQ_W-1:0]   freq_hz,
    input  logic [HEIGHT_W-1:0] height_m,
    input  logic [SPEED_W-1:0]  mean_speed,
    input  logic [SHEAR_W-1:0]  shear_speed,
    output logic                done,
    output logic [DENS_W-1:0]   density,
    output logic [STATUS_W-1:0] status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int LB      = LOG_TABLE_BITS;
    localparam int TSIZE   = (1 << LB) + 1;
    localparam int RW      = 16 - LB;
    localparam int LATENCY = 3 + QA_W + 1 + 3 + 7 + Q1_W + 1 + Q3_W + 1;

    // constant log2 / exp2 tables
    logic [16:0] lt_rom [TSIZE];
    logic [31:0] et_rom [TSIZE];

    generate
        for (genvar gi = 0; gi < TSIZE; gi++)
        begin : g_rom
            localparam logic [16:0] LTV = log_entry(LB, gi);
            localparam logic [31:0] ETV = exp_entry(LB, gi);
            assign lt_rom[gi] = LTV;
            assign et_rom[gi] = ETV;
        end
    endgenerate

    // configuration
    logic [CFG_W-1:0] gain_reg;
    logic [CFG_W-1:0] shape_reg;
    logic             form_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            shape_reg <= SHAPE_RESET;
            form_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_data;
                REG_SHAPE: shape_reg <= cfg_data;
                REG_FORM:  form_reg  <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // front multiply stages
    logic [2:0]        head_vld_reg;
    logic [31:0]       s1_gs_reg;
    logic [FH_W-1:0]   s1_fh_reg;
    logic [15:0]       s1_s_reg;
    logic [H7_W-1:0]   s1_h7_reg;
    logic [DVS_W-1:0]  s1_d_reg;
    logic              s1_zero_reg;
    logic [47:0]       s2_gss_reg;
    logic [60:0]       s2_shfh_reg;
    logic [FH_W-1:0]   s2_fh_reg;
    logic [H7_W-1:0]   s2_h7_reg;
    logic [DVS_W-1:0]  s2_d_reg;
    logic              s2_zero_reg;
    logic [N1_W-1:0]   s3_n1_reg;
    logic [NUMA_W-1:0] s3_num_reg;
    logic [DVS_W-1:0]  s3_d_reg;
    logic              s3_zero_reg;

    logic [H7_W-1:0]  h7;
    logic [DVS_W-1:0] d44;

    assign h7  = {height_m, 3'b000} - {3'b000, height_m};
    assign d44 = {1'b0, mean_speed, 5'b0} + {3'b0, mean_speed, 3'b0} + {4'b0, mean_speed, 2'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0;
        end
        else
        begin
            head_vld_reg <= {head_vld_reg[1:0], start && !busy};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_gs_reg   <= 32'(gain_reg) * 32'(shear_speed);
        s1_fh_reg   <= FH_W'(freq_hz) * FH_W'(h7);
        s1_s_reg    <= shear_speed;
        s1_h7_reg   <= h7;
        s1_d_reg    <= d44;
        s1_zero_reg <= (mean_speed == '0);

        s2_gss_reg  <= 48'(s1_gs_reg) * 48'(s1_s_reg);
        s2_shfh_reg <= 61'(shape_reg) * 61'(s1_fh_reg);
        s2_fh_reg   <= s1_fh_reg;
        s2_h7_reg   <= s1_h7_reg;
        s2_d_reg    <= s1_d_reg;
        s2_zero_reg <= s1_zero_reg;

        s3_n1_reg   <= N1_W'(s2_gss_reg) * N1_W'(s2_h7_reg);
        s3_num_reg  <= form_reg ? NUMA_W'(s2_fh_reg) : s2_shfh_reg[60:8];
        s3_d_reg    <= s2_d_reg;
        s3_zero_reg <= s2_zero_reg;
    end

    // reduced frequency divide
    wtse_carry_t     da_side_in;
    logic [91:0]     da_side_out;
    wtse_carry_t     da_carry;
    logic            da_vld;
    logic [QA_W-1:0] da_q;

    assign da_side_in = '{n1: s3_n1_reg, dvs: s3_d_reg, zero: s3_zero_reg};

    wtse_div #(
        .NW(NUMA_W),
        .DW(DVS_W),
        .QW(QA_W),
        .SW($bits(wtse_carry_t))
    ) u_div_freq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (head_vld_reg[2]),
        .num      (s3_num_reg),
        .den      (s3_d_reg),
        .side_in  (da_side_in),
        .out_vld  (da_vld),
        .quot     (da_q),
        .side_out (da_side_out)
    );

    assign da_carry = wtse_carry_t'(da_side_out);

    // power 5/3 pipeline: s4 operand, three normalize stages, s8..s14
    logic [10:0]      pw_vld_reg;
    logic [V_W-1:0]   s4_v_reg;
    wtse_carry_t      s4_c_reg;
    logic [63:0]      n5_reg, n6_reg, n7_reg;
    logic [5:0]       lz5_reg, lz6_reg, lz7_reg;
    logic             vz5_reg, vz6_reg, vz7_reg;
    wtse_carry_t      c5_reg, c6_reg, c7_reg;
    logic [22:0]      s8_w_reg;
    logic             s8_vz_reg;
    wtse_carry_t      s8_c_reg;
    logic [27:0]      s9_u_reg;
    logic             s9_vz_reg;
    wtse_carry_t      s9_c_reg;
    logic [26:0]      s10_q_reg;
    logic             s10_vz_reg;
    wtse_carry_t      s10_c_reg;
    logic [31:0]      s11_mant_reg;
    logic [10:0]      s11_ip_reg;
    logic             s11_vz_reg;
    wtse_carry_t      s11_c_reg;
    logic [B_W-1:0]   s12_pw_reg;
    wtse_carry_t      s12_c_reg;
    logic [46:0]      s13_ph_reg;
    logic [47:0]      s13_pl_reg;
    logic [B_W-1:0]   s13_pw_reg;
    wtse_carry_t      s13_c_reg;
    logic [B_W-1:0]   s14_b_reg;
    wtse_carry_t      s14_c_reg;

    logic [63:0] n5_next, n6_next, n7_next;
    logic [5:0]  lz5_next, lz6_next, lz7_next;
    logic [63:0] na, nb, nc;

    always_comb
    begin
        na          = {15'b0, s4_v_reg};
        lz5_next    = '0;
        lz5_next[5] = (na[63:32] == '0);
        nb          = lz5_next[5] ? {na[31:0], 32'b0} : na;
        lz5_next[4] = (nb[63:48] == '0);
        n5_next     = lz5_next[4] ? {nb[47:0], 16'b0} : nb;

        lz6_next    = lz5_reg;
        lz6_next[3] = (n5_reg[63:56] == '0);
        nc          = lz6_next[3] ? {n5_reg[55:0], 8'b0} : n5_reg;
        lz6_next[2] = (nc[63:60] == '0);
        n6_next     = lz6_next[2] ? {nc[59:0], 4'b0} : nc;

        lz7_next    = lz6_reg;
        lz7_next[1] = (n6_reg[63:62] == '0);
        n7_next     = lz7_next[1] ? {n6_reg[61:0], 2'b0} : n6_reg;
        lz7_next[0] = !n7_next[63];
        if (lz7_next[0])
        begin
            n7_next = {n7_next[62:0], 1'b0};
        end
    end

    // log2 interpolation
    logic [31:0]   lt_t;
    logic [LB-1:0] lt_idx;
    logic [15:0]   lt_r;
    logic [16:0]   lt_lo, lt_hi, lt_d;
    logic [32:0]   lt_prod;
    logic [5:0]    lg_e;
    logic [22:0]   s8_w_next;

    assign lt_t      = n7_reg[62:31];
    assign lt_idx    = lt_t[31 -: LB];
    assign lt_r      = lt_t[31-LB -: 16];
    assign lt_lo     = lt_rom[{1'b0, lt_idx}];
    assign lt_hi     = lt_rom[{1'b0, lt_idx} + 1'b1];
    assign lt_d      = lt_hi - lt_lo;
    assign lt_prod   = 33'(lt_d) * 33'(lt_r);
    assign lg_e      = ~lz7_reg;
    assign s8_w_next = {1'b0, lg_e, 16'b0} + 23'(lt_lo) + 23'(lt_prod[32:16]);

    // 5/3 scaling
    logic [27:0] s9_u_next;
    logic [58:0] r3_prod;

    assign s9_u_next = {s8_w_reg, 2'b0} + 28'(s8_w_reg) + U_BIAS;
    assign r3_prod   = 59'(s9_u_reg) * 59'(RECIP3);

    // exp2 interpolation
    logic [15:0]   ex_fr;
    logic [LB-1:0] ex_idx;
    logic [RW-1:0] ex_rem;
    logic [31:0]   ex_lo, ex_hi, ex_d;
    logic [47:0]   ex_prod;
    logic [31:0]   s11_mant_next;

    assign ex_fr         = s10_q_reg[15:0];
    assign ex_idx        = ex_fr[15 -: LB];
    assign ex_rem        = ex_fr[RW-1:0];
    assign ex_lo         = et_rom[{1'b0, ex_idx}];
    assign ex_hi         = et_rom[{1'b0, ex_idx} + 1'b1];
    assign ex_d          = ex_hi - ex_lo;
    assign ex_prod       = 48'(ex_d) * 48'(ex_rem);
    assign s11_mant_next = ex_lo + ex_prod[RW +: 32];

    // Q30 mantissa to Q16 result, clamped
    logic [B_W-1:0] s12_pw_next;
    logic [10:0]    sh_amt;
    logic [B_W-1:0] sh_val;

    always_comb
    begin
        sh_amt      = '0;
        sh_val      = '0;
        s12_pw_next = '0;
        if (s11_vz_reg)
        begin
            s12_pw_next = '0;
        end
        else if (s11_ip_reg < IP_BIAS)
        begin
            sh_amt = IP_BIAS - s11_ip_reg;
            if (sh_amt >= 11'd63)
            begin
                s12_pw_next = '0;
            end
            else
            begin
                s12_pw_next = {31'b0, s11_mant_reg} >> sh_amt[5:0];
            end
        end
        else
        begin
            sh_amt = s11_ip_reg - IP_BIAS;
            if (sh_amt >= 11'd31)
            begin
                s12_pw_next = POW_MAX;
            end
            else
            begin
                sh_val      = {31'b0, s11_mant_reg} << sh_amt[4:0];
                s12_pw_next = (sh_val > POW_MAX) ? POW_MAX : sh_val;
            end
        end
    end

    // denominator assembly
    logic [78:0]    b_prod;
    logic [B_W-1:0] b_vert;
    logic [B_W-1:0] b_sel;
    logic [B_W-1:0] s14_b_next;

    assign b_prod     = {s13_ph_reg, 32'b0} + 79'(s13_pl_reg);
    assign b_vert     = (b_prod > 79'(POW_MAX)) ? POW_MAX : ONE_Q16 + b_prod[70:8];
    assign b_sel      = form_reg ? b_vert : s13_pw_reg;
    assign s14_b_next = (b_sel < ONE_Q16) ? ONE_Q16 : b_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_vld_reg <= '0;
        end
        else
        begin
            pw_vld_reg <= {pw_vld_reg[9:0], da_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        s4_v_reg     <= form_reg ? V_W'(da_q) : V_W'(da_q) + V_W'(ONE_Q16);
        s4_c_reg     <= da_carry;

        n5_reg       <= n5_next;
        lz5_reg      <= lz5_next;
        vz5_reg      <= (s4_v_reg == '0);
        c5_reg       <= s4_c_reg;
        n6_reg       <= n6_next;
        lz6_reg      <= lz6_next;
        vz6_reg      <= vz5_reg;
        c6_reg       <= c5_reg;
        n7_reg       <= n7_next;
        lz7_reg      <= lz7_next;
        vz7_reg      <= vz6_reg;
        c7_reg       <= c6_reg;

        s8_w_reg     <= s8_w_next;
        s8_vz_reg    <= vz7_reg;
        s8_c_reg     <= c7_reg;
        s9_u_reg     <= s9_u_next;
        s9_vz_reg    <= s8_vz_reg;
        s9_c_reg     <= s8_c_reg;
        s10_q_reg    <= r3_prod[56:30];
        s10_vz_reg   <= s9_vz_reg;
        s10_c_reg    <= s9_c_reg;
        s11_mant_reg <= s11_mant_next;
        s11_ip_reg   <= s10_q_reg[26:16];
        s11_vz_reg   <= s10_vz_reg;
        s11_c_reg    <= s10_c_reg;
        s12_pw_reg   <= s12_pw_next;
        s12_c_reg    <= s11_c_reg;
        s13_ph_reg   <= 47'(s12_pw_reg[62:32]) * 47'(shape_reg);
        s13_pl_reg   <= 48'(s12_pw_reg[31:0]) * 48'(shape_reg);
        s13_pw_reg   <= s12_pw_reg;
        s13_c_reg    <= s12_c_reg;
        s14_b_reg    <= s14_b_next;
        s14_c_reg    <= s13_c_reg;
    end

    // amplitude divide
    wtse_tail_t      d1_side_in;
    logic [63:0]     d1_side_out;
    wtse_tail_t      d1_tail;
    logic            d1_vld;
    logic [Q1_W-1:0] d1_q;

    assign d1_side_in = '{bq: s14_b_reg, zero: s14_c_reg.zero};

    wtse_div #(
        .NW(N1_W),
        .DW(DVS_W),
        .QW(Q1_W),
        .SW($bits(wtse_tail_t))
    ) u_div_amp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (pw_vld_reg[10]),
        .num      (s14_c_reg.n1),
        .den      (s14_c_reg.dvs),
        .side_in  (d1_side_in),
        .out_vld  (d1_vld),
        .quot     (d1_q),
        .side_out (d1_side_out)
    );

    assign d1_tail = wtse_tail_t'(d1_side_out);

    logic              s15_vld_reg;
    logic [NUM3_W-1:0] s15_num_reg;
    logic [B_W-1:0]    s15_b_reg;
    logic              s15_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s15_vld_reg <= 1'b0;
        end
        else
        begin
            s15_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s15_num_reg  <= {d1_q[63:16], 8'b0};
        s15_b_reg    <= d1_tail.bq;
        s15_zero_reg <= d1_tail.zero;
    end

    // final divide; numerator < 2^56 and B >= 2^16 keep the quotient in 40 bits
    logic            d3_vld;
    logic [Q3_W-1:0] d3_q;
    logic            d3_zero;

    wtse_div #(
        .NW(NUM3_W),
        .DW(B_W),
        .QW(Q3_W),
        .SW(1)
    ) u_div_dens (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s15_vld_reg),
        .num      (s15_num_reg),
        .den      (s15_b_reg),
        .side_in  (s15_zero_reg),
        .out_vld  (d3_vld),
        .quot     (d3_q),
        .side_out (d3_zero)
    );

    logic              done_reg;
    logic [DENS_W-1:0] density_reg;
    status_t           status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        density_reg <= d3_zero ? '0 : d3_q;
        status_reg  <= d3_zero ? ST_ZERO : ST_OK;
    end

    assign done    = done_reg;
    assign density = density_reg;
    assign status  = status_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction did not complete at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching transaction");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(mean_speed == '0, LATENCY) == (status == ST_ZERO)))
        else $error("zero mean speed flag mismatch");

    a_zero_density: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ZERO) |-> (density == '0))
        else $error("nonzero density on zero mean speed");

endmodule
